### sv/namespaced_word_store_core_macros.svh
// Assertion macros used by the checker file.
`ifndef NAMESPACED_WORD_STORE_CORE_MACROS_SVH
`define NAMESPACED_WORD_STORE_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define NWS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define NWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/nws_pkg.sv
// Package with the store depths, action and status codes of the word store.
package nws_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int OWNER_DEPTH = 1024;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int OWNER_AW    = (OWNER_DEPTH > 1) ? $clog2(OWNER_DEPTH) : 1;
    localparam int STORE_CW    = $clog2(STORE_DEPTH + 1);
    localparam int OWNER_CW    = $clog2(OWNER_DEPTH + 1);

    localparam logic [63:0] DEFAULT_ADDRESS = 64'h1000;
    localparam int ROT1 = 17;
    localparam int ROT2 = 31;
    localparam int ROT3 = 45;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_STORE = 2'd1,
        ACT_OWNER = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_MISS       = 3'd1;
    localparam logic [2:0] ST_OWNER      = 3'd2;
    localparam logic [2:0] ST_STORE_FULL = 3'd3;
    localparam logic [2:0] ST_OWNER_FULL = 3'd4;

    localparam int IN_W  = 2 + 64 * 9;
    localparam int IN_TW = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W = 256 + 3 + 1;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    function automatic logic [63:0] rotr64(input logic [63:0] x, input int r);
        rotr64 = (x >> r) | (x << (64 - r));
    endfunction

endpackage

### sv/namespaced_word_store_core.sv
// Word store: one beat in, linear key scan over memories, one beat out.
// A load scans the stored keys and, on a miss, the owner keys; a store scans
//   the stored keys and an owner add the owner keys; a hit ends the scan early.
// Throughput: one item at a time; each scan step is one read of a key memory.
// Reset: asynchronous active low; clears counts, dirty flag and control state.
// Memory contents are not cleared; only entries below the counts are used.
module namespaced_word_store_core (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // action[1:0], caller_address, key_word0..3, data_word0..3, zero pad
    input  logic [nws_pkg::IN_TW-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // read_word0..3, status[2:0], dirty, zero pad
    output logic [nws_pkg::OUT_TW-1:0] m_axis_tdata
);
    import nws_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SKEY  = 6'b000010,
        S_OKEY  = 6'b000100,
        S_VAL   = 6'b001000,
        S_WRITE = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [255:0] key_mem   [STORE_DEPTH];
    logic [255:0] value_mem [STORE_DEPTH];
    logic [63:0]  writer_mem[STORE_DEPTH];
    logic [255:0] owner_mem [OWNER_DEPTH];

    logic [1:0]   act_reg;
    logic [63:0]  caller_reg;
    logic [255:0] key_reg, data_reg;
    logic [STORE_CW-1:0] entry_count_reg;
    logic [OWNER_CW-1:0] owner_count_reg;
    logic         dirty_reg;
    logic [STORE_CW-1:0] sidx_reg;
    logic [OWNER_CW-1:0] oidx_reg;
    logic         rd_pend_reg;
    logic [255:0] skey_q, okey_q, val_q;
    logic         hit_reg;
    logic [255:0] rd_reg;
    logic [2:0]   status_reg;

    logic [63:0]  in_caller, eff_addr;
    logic [255:0] in_key, in_data, ns_key;
    logic [1:0]   in_act;

    assign in_act    = s_axis_tdata[1:0];
    assign in_caller = s_axis_tdata[65:2];
    assign in_key    = s_axis_tdata[321:66];
    assign in_data   = s_axis_tdata[577:322];
    assign eff_addr  = (in_caller == 64'd0) ? DEFAULT_ADDRESS : in_caller;
    assign ns_key = in_key ^ {rotr64(eff_addr, ROT3), rotr64(eff_addr, ROT2),
                              rotr64(eff_addr, ROT1), eff_addr};

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = state_reg == S_OUT;
    assign m_axis_tdata  = {{(OUT_TW-OUT_W){1'b0}}, dirty_reg, status_reg, rd_reg};

    // Memory ports: synchronous reads of the entry under the scan index.
    logic sk_wr, ow_wr, val_wr;
    logic [STORE_AW-1:0] s_addr, s_wr_addr;
    logic [OWNER_AW-1:0] o_addr;
    assign s_addr = sidx_reg[STORE_AW-1:0];
    assign o_addr = oidx_reg[OWNER_AW-1:0];

    always_ff @(posedge clk)
    begin
        skey_q <= key_mem[s_addr];
        okey_q <= owner_mem[o_addr];
        val_q  <= value_mem[s_addr];
        if (sk_wr)
        begin
            key_mem[s_wr_addr] <= key_reg;
        end
        if (val_wr)
        begin
            value_mem[s_wr_addr]  <= data_reg;
            writer_mem[s_wr_addr] <= caller_reg;
        end
        if (ow_wr)
        begin
            owner_mem[owner_count_reg[OWNER_AW-1:0]] <= key_reg;
        end
    end

    logic s_scan_end, o_scan_end, s_match, o_match;
    assign s_scan_end = sidx_reg >= entry_count_reg;
    assign o_scan_end = oidx_reg >= owner_count_reg;
    assign s_match = rd_pend_reg && (skey_q == key_reg);
    assign o_match = rd_pend_reg && (okey_q == key_reg);

    always_comb
    begin
        state_next = state_reg;
        sk_wr = 1'b0;
        val_wr = 1'b0;
        ow_wr = 1'b0;
        s_wr_addr = s_addr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    unique case (in_act)
                        ACT_LOAD, ACT_STORE: state_next = S_SKEY;
                        ACT_OWNER:           state_next = S_OKEY;
                        default:             state_next = S_OUT;
                    endcase
                end
            end
            S_SKEY:
            begin
                if (s_match)
                begin
                    state_next = S_VAL;
                end
                else if (s_scan_end && !rd_pend_reg)
                begin
                    if (act_reg == ACT_LOAD)
                    begin
                        state_next = S_OKEY;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_OKEY:
            begin
                if (o_match || (o_scan_end && !rd_pend_reg))
                begin
                    state_next = S_OUT;
                end
            end
            S_VAL:
            begin
                // Hold while the value of the hit entry is read.
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                state_next = S_OUT;
                if (act_reg == ACT_STORE)
                begin
                    if (!hit_reg && entry_count_reg < STORE_CW'(STORE_DEPTH))
                    begin
                        sk_wr = 1'b1;
                        val_wr = 1'b1;
                        s_wr_addr = entry_count_reg[STORE_AW-1:0];
                    end
                    else if (hit_reg)
                    begin
                        val_wr = 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_OKEY && act_reg == ACT_OWNER && !o_match
            && o_scan_end && !rd_pend_reg && owner_count_reg < OWNER_CW'(OWNER_DEPTH))
        begin
            ow_wr = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            owner_count_reg <= '0;
            dirty_reg       <= 1'b0;
            rd_pend_reg     <= 1'b0;
            sidx_reg        <= '0;
            oidx_reg        <= '0;
            hit_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    sidx_reg    <= '0;
                    oidx_reg    <= '0;
                    rd_pend_reg <= 1'b0;
                    hit_reg     <= 1'b0;
                end
                S_SKEY:
                begin
                    // Index advances each cycle until hit or end; compare lags.
                    rd_pend_reg <= !s_scan_end && !s_match;
                    if (s_match)
                    begin
                        hit_reg  <= 1'b1;
                        sidx_reg <= sidx_reg - STORE_CW'(1);
                    end
                    else if (!s_scan_end)
                    begin
                        sidx_reg <= sidx_reg + STORE_CW'(1);
                    end
                end
                S_OKEY:
                begin
                    rd_pend_reg <= !o_scan_end && !o_match;
                    if (!o_scan_end && !o_match)
                    begin
                        oidx_reg <= oidx_reg + OWNER_CW'(1);
                    end
                    if (ow_wr)
                    begin
                        owner_count_reg <= owner_count_reg + OWNER_CW'(1);
                    end
                end
                S_WRITE:
                begin
                    if (sk_wr)
                    begin
                        entry_count_reg <= entry_count_reg + STORE_CW'(1);
                        dirty_reg <= 1'b1;
                    end
                    else if (hit_reg && act_reg == ACT_STORE && val_q != data_reg)
                    begin
                        dirty_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload and result registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            act_reg    <= in_act;
            caller_reg <= in_caller;
            key_reg    <= (in_act == ACT_OWNER) ? in_key : ns_key;
            data_reg   <= in_data;
            rd_reg     <= '0;
            status_reg <= ST_OK;
        end
        else if (state_reg == S_OKEY && (o_match || (o_scan_end && !rd_pend_reg)))
        begin
            if (act_reg == ACT_LOAD)
            begin
                rd_reg     <= o_match ? 256'd1 : 256'd0;
                status_reg <= o_match ? ST_OWNER : ST_MISS;
            end
            else if (!o_match && !ow_wr)
            begin
                status_reg <= ST_OWNER_FULL;
            end
        end
        else if (state_reg == S_WRITE && act_reg == ACT_LOAD)
        begin
            rd_reg <= val_q;
        end
        else if (state_reg == S_VAL)
        begin
            status_reg <= ST_OK;
        end
        else if (state_reg == S_WRITE && !hit_reg && !sk_wr)
        begin
            status_reg <= ST_STORE_FULL;
        end
    end

endmodule

### sv/nws_checker.sv
// Port-level checker for the word store core, bound to the core module.
`include "namespaced_word_store_core_macros.svh"
module nws_checker (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [nws_pkg::OUT_TW-1:0] m_axis_tdata
);
    import nws_pkg::*;

    `NWS_ASSERT_IMPL(a_one_side, clk, rst_n, m_axis_tvalid, !s_axis_tready, "accept while result held")
    `NWS_ASSERT_NEXT(a_dirty_sticky, clk, rst_n, m_axis_tvalid && m_axis_tdata[259], m_axis_tvalid ? m_axis_tdata[259] : 1'b1, "dirty dropped")
    `NWS_ASSERT_IMPL(a_status_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[258:256] <= ST_OWNER_FULL, "bad status")
    `NWS_ASSERT_IMPL(a_owner_one, clk, rst_n, m_axis_tvalid && m_axis_tdata[258:256] == ST_OWNER, m_axis_tdata[255:0] == 256'd1, "owner load not one")

endmodule

bind namespaced_word_store_core nws_checker u_nws_checker (.*);

### bench/tb_namespaced_word_store_core.sv
// Self-checking bench for the namespaced word store core.
`timescale 1ns / 100ps

module tb_namespaced_word_store_core;
    import nws_pkg::*;

    typedef struct packed {
        logic [63:0] w3;
        logic [63:0] w2;
        logic [63:0] w1;
        logic [63:0] w0;
    } word256_t;

    typedef struct {
        word256_t   value;
        logic [2:0] status;
        logic       dirty;
    } reply_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_TW-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_TW-1:0] m_axis_tdata;

    // shadow of the block's tables
    word256_t   shadow_keys[$];
    word256_t   shadow_values[$];
    word256_t   shadow_owners[$];
    logic       shadow_dirty;
    reply_t     expected_replies[$];
    word256_t   used_keys[$];
    logic [63:0] used_callers[$];

    int  error_count;
    int  beats_sent;
    int  beats_checked;
    bit  idle_enabled;

    namespaced_word_store_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] rotate_right(logic [63:0] x, int r);
        return (x >> r) | (x << (64 - r));
    endfunction

    function automatic word256_t scramble_key(word256_t k, logic [63:0] caller);
        logic [63:0] a;
        word256_t    s;
        a = (caller == 64'd0) ? DEFAULT_ADDRESS : caller;
        s.w0 = k.w0 ^ a;
        s.w1 = k.w1 ^ rotate_right(a, ROT1);
        s.w2 = k.w2 ^ rotate_right(a, ROT2);
        s.w3 = k.w3 ^ rotate_right(a, ROT3);
        return s;
    endfunction

    function automatic int find_stored(word256_t k);
        foreach (shadow_keys[i])
            if (shadow_keys[i] == k)
                return i;
        return -1;
    endfunction

    function automatic bit owner_known(word256_t k);
        foreach (shadow_owners[i])
            if (shadow_owners[i] == k)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic reply_t predict_access(action_t act, logic [63:0] caller,
                                              word256_t key, word256_t data);
        reply_t   r;
        word256_t nk;
        int       hit;
        r.value  = '0;
        r.status = ST_OK;
        if (act == ACT_LOAD || act == ACT_STORE) begin
            nk  = scramble_key(key, caller);
            hit = find_stored(nk);
            if (act == ACT_LOAD) begin
                if (hit >= 0)
                    r.value = shadow_values[hit];
                else if (owner_known(nk)) begin
                    r.value.w0 = 64'd1;
                    r.status   = ST_OWNER;
                end
                else
                    r.status = ST_MISS;
            end
            else if (hit >= 0) begin
                if (shadow_values[hit] != data) begin
                    shadow_values[hit] = data;
                    shadow_dirty = 1'b1;
                end
            end
            else if (shadow_keys.size() < STORE_DEPTH) begin
                shadow_keys.push_back(nk);
                shadow_values.push_back(data);
                shadow_dirty = 1'b1;
            end
            else
                r.status = ST_STORE_FULL;
        end
        else if (act == ACT_OWNER) begin
            if (!owner_known(key)) begin
                if (shadow_owners.size() < OWNER_DEPTH)
                    shadow_owners.push_back(key);
                else
                    r.status = ST_OWNER_FULL;
            end
        end
        r.dirty = shadow_dirty;
        return r;
    endfunction

    function automatic word256_t random_word();
        word256_t w;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return w;
    endfunction

    function automatic logic [63:0] random_caller();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return DEFAULT_ADDRESS;
            2: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // while idle gaps are enabled, sometimes drop valid for a random gap
    task automatic idle_gap();
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_beat(action_t act, logic [63:0] caller, word256_t key,
                             word256_t data);
        idle_gap();
        expected_replies.push_back(predict_access(act, caller, key, data));
        s_axis_tdata  <= {{(IN_TW - IN_W){1'b0}}, data, key, caller, act};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beats_sent++;
        if (act == ACT_STORE || act == ACT_LOAD) begin
            used_keys.push_back(key);
            used_callers.push_back(caller);
        end
    endtask

    // result checker
    initial
    begin
        reply_t   exp_r;
        word256_t got_value;
        logic [2:0] got_status;
        logic     got_dirty;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got_value  = m_axis_tdata[255:0];
                got_status = m_axis_tdata[258:256];
                got_dirty  = m_axis_tdata[259];
                beats_checked++;
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, m_axis_tdata);
                    error_count++;
                end
                else begin
                    exp_r = expected_replies.pop_front();
                    if (got_value !== exp_r.value) begin
                        $display("%0t: value expected %h actual %h", $time,
                                 exp_r.value, got_value);
                        error_count++;
                    end
                    if (got_status !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_r.status, got_status);
                        error_count++;
                    end
                    if (got_dirty !== exp_r.dirty) begin
                        $display("%0t: dirty expected %0b actual %0b", $time,
                                 exp_r.dirty, got_dirty);
                        error_count++;
                    end
                end
            end
        end
    end

    // output back-pressure
    initial
    begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (idle_enabled && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        word256_t k0;
        word256_t d0;
        k0 = random_word();
        d0 = random_word();
        send_beat(ACT_LOAD, 64'd0, '0, '0);              // miss on empty table
        send_beat(ACT_STORE, 64'd0, '0, '1);             // zero caller substituted
        send_beat(ACT_LOAD, DEFAULT_ADDRESS, '0, '0);    // same namespace
        send_beat(ACT_LOAD, 64'd1, '0, '0);
        send_beat(ACT_STORE, '1, '1, '0);
        send_beat(ACT_LOAD, '1, '1, '1);
        send_beat(ACT_STORE, '1, '1, '0);                // unchanged value
        send_beat(ACT_STORE, 64'h5, k0, d0);
        send_beat(ACT_STORE, 64'h5, k0, ~d0);            // overwrite
        send_beat(ACT_LOAD, 64'h5, k0, '0);
        send_beat(ACT_OWNER, 64'd0, '1, '0);
        send_beat(ACT_OWNER, 64'd0, '1, '0);             // duplicate owner key
        send_beat(ACT_OWNER, 64'd0, scramble_key(k0, 64'h9), '0);
        send_beat(ACT_LOAD, 64'h9, k0, '0);              // owner hit returns one
        send_beat(ACT_NONE, '1, '1, '1);
        send_beat(ACT_LOAD, 64'h5, '1, '1);
    endtask

    task automatic test_random(int count);
        int       pick;
        int       idx;
        word256_t key;
        logic [63:0] caller;
        for (int n = 0; n < count; n++) begin
            if (n > count * 3 / 4)
                idle_enabled = 1'b0;
            caller = random_caller();
            key    = random_word();
            // reuse earlier keys often so loads and stores hit
            if (used_keys.size() > 0 && $urandom_range(0, 1)) begin
                idx    = $urandom_range(0, used_keys.size() - 1);
                key    = used_keys[idx];
                caller = used_callers[idx];
            end
            pick = $urandom_range(0, 9);
            if (pick < 4)
                send_beat(ACT_LOAD, caller, key, random_word());
            else if (pick < 8)
                send_beat(ACT_STORE, caller, key, random_word());
            else if (pick == 8)
                send_beat(ACT_OWNER, caller,
                          $urandom_range(0, 1) ? scramble_key(key, caller) : key, '0);
            else
                send_beat(ACT_NONE, caller, key, random_word());
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        error_count   = 0;
        beats_sent    = 0;
        beats_checked = 0;
        idle_enabled  = 1'b1;
        shadow_dirty  = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(275);
        wait_drain();
        $display("Covered %0d beats in, %0d checked; %0d stored keys, %0d owner keys.",
                 beats_sent, beats_checked, shadow_keys.size(), shadow_owners.size());
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/nws_pkg.sv
sv/namespaced_word_store_core.sv
sv/nws_checker.sv
bench/tb_namespaced_word_store_core.sv
